// ===== hw/rtl/dicrle_pkg.sv =====
// Package for the DICOM RLE frame decoder.
// Holds frame constants, run-mode and register-index codes, and small helper functions.
// No dependencies.
`timescale 1ns / 1ps

package dicrle_pkg;

    // Frame header length in bytes (segment count plus fifteen offsets).
    localparam int HEADER_BYTES = 64;
    // Default limit on the number of segments in one frame.
    localparam int MAX_SEGMENTS_DEF = 15;

    // Largest plane size in pixels.
    localparam logic [24:0] MAX_PIXELS = 25'd16777216;
    // Run header byte that does nothing (-128).
    localparam logic [7:0] NOOP_CODE = 8'h80;

    // Configuration register reset values.
    localparam logic [24:0] PIXELS_RESET = 25'd262144;
    localparam logic [2:0]  BPS_RESET    = 3'd2;
    localparam logic [2:0]  SPP_RESET    = 3'd1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PIXELS_PER_FRAME  = 2'd0,
        CFG_BYTES_PER_SAMPLE  = 2'd1,
        CFG_SAMPLES_PER_PIXEL = 2'd2
    } cfg_index_t;

    // PackBits decoding state within a segment.
    typedef enum logic [1:0] {
        MODE_HEADER    = 2'd0,
        MODE_LITERAL   = 2'd1,
        MODE_REPLICATE = 2'd2
    } run_mode_t;

    // Channel and byte lane of one segment.
    typedef struct packed {
        logic [1:0] sample;
        logic [1:0] lane;
    } lane_sel_t;

    // Saturate a 3-bit count to the range 1..4.
    function automatic logic [2:0] clamp14(input logic [2:0] v);
        logic [2:0] r;
        begin
            if (v == 3'd0) begin
                r = 3'd1;
            end else if (v > 3'd4) begin
                r = 3'd4;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

    // Split a segment index into channel and MSB-first byte lane.
    // The index is below 16, so division by three is a multiply by 11 and a shift.
    function automatic lane_sel_t seg_to_lane(input logic [3:0] seg, input logic [2:0] bps);
        lane_sel_t  r;
        logic [7:0] prod;
        logic [2:0] q3;
        logic [3:0] rem;
        begin
            prod = 8'({4'd0, seg} * 8'd11);
            q3   = 3'd0;
            rem  = 4'd0;
            case (bps)
                3'd1: begin
                    q3  = seg[2:0];
                    rem = 4'd0;
                end
                3'd2: begin
                    q3  = seg[3:1];
                    rem = {3'd0, seg[0]};
                end
                3'd3: begin
                    q3  = prod[7:5];
                    rem = seg - ({1'b0, q3} * 4'd3);
                end
                3'd4: begin
                    q3  = {1'b0, seg[3:2]};
                    rem = {2'd0, seg[1:0]};
                end
                default: begin
                    q3  = 3'd0;
                    rem = 4'd0;
                end
            endcase
            r.sample = q3[1:0];
            r.lane   = 2'(bps - 3'd1 - rem[2:0]);
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/dicrle_seg_track.sv =====
// Segment offset store and segment start search for the DICOM RLE decoder.
// Depends on dicrle_pkg.
`timescale 1ns / 1ps

module dicrle_seg_track
    import dicrle_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [3:0]       wr_idx,
    input  logic [31:0]      wr_data,
    input  logic [31:0]      position,
    input  logic [SEG_W-1:0] seg_count,
    input  logic [SEG_W-1:0] active,
    output logic [SEG_W-1:0] active_next
);

    logic [31:0]             offset_reg [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] reached;

    // Offsets are written from the header; their contents before that are don't-care.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (wr_en && wr_idx == 4'(i)) begin
                offset_reg[i] <= wr_data;
            end
        end
    end

    // A segment is reached when it exists and its offset is at or below the position.
    always_comb begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            reached[i] = (SEG_W'(i) < seg_count) && (offset_reg[i] <= position);
        end
    end

    // The new active count is the first segment at or after the current one that is
    // not yet reached; every reached segment before it is started in order.
    always_comb begin
        active_next = SEG_W'(MAX_SEGMENTS);
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
            if (SEG_W'(i) >= active && !reached[i]) begin
                active_next = SEG_W'(i);
            end
        end
    end

endmodule

// ===== hw/rtl/dicom_rle_packbits_decoder.sv =====
// Top level of the DICOM RLE (PackBits) frame decoder.
// Depends on dicrle_pkg and dicrle_seg_track.
`timescale 1ns / 1ps

// The decoder takes one compressed DICOM RLE frame as a byte stream, one byte per
// request, and emits one run request for each literal byte or replicated value: the
// value, how many pixels take it, the first pixel, the channel and the MSB-first byte
// lane. The 64-byte header is captured first. The final byte (tlast) always yields a
// request with tlast set and a status in tuser: 0 ok, 1 short header, 2 more segments
// than channel planes. Each byte passes an input register, one stage of decode logic
// and an output register; a new byte is taken every cycle unless the output stalls.
// The decode stage holds the offset compare over all segments and the run-length clip.
// Configuration must be written only while no request is in flight; it is not enforced.
module dicom_rle_packbits_decoder
    import dicrle_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [24:0] cfg_wr_data,
    // Compressed byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last
    // Decoded runs.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] value, [15:8] run_length, [39:16] pixel_start,
                                   // [41:40] sample_index, [43:42] byte_lane, [47:44] zero
    output logic        m_tlast,   // frame_done
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);

    // Configuration registers.
    logic [24:0] ppf_reg;
    logic [2:0]  bps_reg;
    logic [2:0]  spp_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Frame state.
    logic [31:0]      byte_pos_reg, byte_pos_next;
    logic [31:0]      hdr_word_reg, hdr_word_next;
    logic [31:0]      seg_total_reg, seg_total_next;
    logic [SEG_W-1:0] active_reg, active_next;
    run_mode_t        mode_reg, mode_next;
    logic [7:0]       remain_reg, remain_next;
    logic [7:0]       repeat_reg, repeat_next;
    logic [24:0]      pix_done_reg, pix_done_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;
    logic [1:0]  m_user_reg, m_user_next;

    // Offset store interface.
    logic             off_wr_en;
    logic [3:0]       off_wr_idx;
    logic [SEG_W-1:0] seg_count;
    logic [SEG_W-1:0] search_active;

    logic advance;
    logic fire;

    assign advance  = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Segment count in use, cut to the number of offset slots.
    assign seg_count = (seg_total_reg < 32'(MAX_SEGMENTS)) ? seg_total_reg[SEG_W-1:0]
                                                           : SEG_W'(MAX_SEGMENTS);

    dicrle_seg_track #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_seg_track (
        .aclk       (aclk),
        .wr_en      (off_wr_en),
        .wr_idx     (off_wr_idx),
        .wr_data    (hdr_word_next),
        .position   (byte_pos_reg),
        .seg_count  (seg_count),
        .active     (active_reg),
        .active_next(search_active)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppf_reg <= PIXELS_RESET;
            bps_reg <= BPS_RESET;
            spp_reg <= SPP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                CFG_PIXELS_PER_FRAME:  ppf_reg <= cfg_wr_data;
                CFG_BYTES_PER_SAMPLE:  bps_reg <= cfg_wr_data[2:0];
                CFG_SAMPLES_PER_PIXEL: spp_reg <= cfg_wr_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Decode of one byte: header capture, segment start, run state and clipping.
    always_comb begin
        logic [31:0] p;
        logic [2:0]  bps;
        logic [4:0]  planes;
        logic [3:0]  seg;
        logic [7:0]  count;
        logic [24:0] npix;
        logic [24:0] room;
        logic [7:0]  run_len;
        logic        have;
        logic [1:0]  status;
        lane_sel_t   sel;

        p       = byte_pos_reg;
        bps     = clamp14(bps_reg);
        planes  = {2'd0, bps} * {2'd0, clamp14(spp_reg)};
        seg     = 4'(5'(active_reg) - 5'd1);
        count   = 8'd0;
        npix    = (ppf_reg > MAX_PIXELS) ? MAX_PIXELS : ppf_reg;
        room    = 25'd0;
        run_len = 8'd0;
        have    = 1'b0;
        status  = 2'd0;
        sel     = seg_to_lane(seg, bps);

        byte_pos_next  = byte_pos_reg;
        hdr_word_next  = hdr_word_reg;
        seg_total_next = seg_total_reg;
        active_next    = active_reg;
        mode_next      = mode_reg;
        remain_next    = remain_reg;
        repeat_next    = repeat_reg;
        pix_done_next  = pix_done_reg;
        off_wr_en      = 1'b0;
        off_wr_idx     = 4'(p[5:2] - 4'd1);

        m_valid_next = 1'b0;
        m_data_next  = '0;
        m_last_next  = in_last_reg;
        m_user_next  = 2'd0;

        if (fire) begin
            if (p < 32'(HEADER_BYTES)) begin
                // Header: gather little-endian words.
                hdr_word_next = {in_byte_reg, hdr_word_reg[31:8]};
                if (p[1:0] == 2'b11) begin
                    if (p[5:2] == 4'd0) begin
                        seg_total_next = hdr_word_next;
                    end else begin
                        off_wr_en = (off_wr_idx < 4'(MAX_SEGMENTS));
                    end
                end
            end else begin
                // Start any segments whose offsets have been reached.
                active_next = search_active;
                if (search_active != active_reg) begin
                    mode_next     = MODE_HEADER;
                    remain_next   = 8'd0;
                    repeat_next   = 8'd0;
                    pix_done_next = 25'd0;
                end
                seg = 4'(5'(active_next) - 5'd1);
                sel = seg_to_lane(seg, bps);
                if (active_next != '0 && (5'(active_next) - 5'd1) < planes) begin
                    // PackBits run state.
                    case (mode_next)
                        MODE_LITERAL: begin
                            count = 8'd1;
                            if (remain_next != 8'd0) begin
                                remain_next = remain_next - 8'd1;
                            end
                            if (remain_next == 8'd0) begin
                                mode_next = MODE_HEADER;
                            end
                        end
                        MODE_REPLICATE: begin
                            count     = repeat_next;
                            mode_next = MODE_HEADER;
                        end
                        default: begin
                            if (!in_byte_reg[7]) begin
                                mode_next   = MODE_LITERAL;
                                remain_next = in_byte_reg + 8'd1;
                            end else if (in_byte_reg != NOOP_CODE) begin
                                mode_next   = MODE_REPLICATE;
                                repeat_next = 8'(9'd257 - {1'b0, in_byte_reg});
                            end else begin
                                mode_next = MODE_HEADER;
                            end
                        end
                    endcase
                    // Clip the run to the plane size.
                    if (count != 8'd0 && pix_done_next < npix) begin
                        room          = npix - pix_done_next;
                        run_len       = (25'(count) < room) ? count : room[7:0];
                        have          = 1'b1;
                        m_data_next   = {4'd0, sel.lane, sel.sample, pix_done_next[23:0],
                                         run_len, in_byte_reg};
                        pix_done_next = pix_done_next + 25'(run_len);
                    end
                end
            end

            byte_pos_next = (p == 32'hFFFF_FFFF) ? p : p + 32'd1;

            if (in_last_reg && p < 32'(HEADER_BYTES - 1)) begin
                status = 2'd1;
            end else if (seg_total_next > 32'(planes)) begin
                status = 2'd2;
            end
            m_valid_next = have || in_last_reg;
            m_user_next  = status;

            // End of frame: back to the reset state, registers and offsets kept.
            if (in_last_reg) begin
                byte_pos_next  = 32'd0;
                hdr_word_next  = 32'd0;
                seg_total_next = 32'd0;
                active_next    = '0;
                mode_next      = MODE_HEADER;
                remain_next    = 8'd0;
                repeat_next    = 8'd0;
                pix_done_next  = 25'd0;
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg  <= 32'd0;
            hdr_word_reg  <= 32'd0;
            seg_total_reg <= 32'd0;
            active_reg    <= '0;
            mode_reg      <= MODE_HEADER;
            remain_reg    <= 8'd0;
            repeat_reg    <= 8'd0;
            pix_done_reg  <= 25'd0;
        end else begin
            byte_pos_reg  <= byte_pos_next;
            hdr_word_reg  <= hdr_word_next;
            seg_total_reg <= seg_total_next;
            active_reg    <= active_next;
            mode_reg      <= mode_next;
            remain_reg    <= remain_next;
            repeat_reg    <= repeat_next;
            pix_done_reg  <= pix_done_next;
        end
    end

    // Output register: loaded on every decoded byte, emptied when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= m_valid_next;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (fire) begin
            m_data_reg <= m_data_next;
            m_last_reg <= m_last_next;
            m_user_reg <= m_user_next;
        end
    end

    // The frame position starts over after the final byte of a frame.
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> byte_pos_reg == 32'd0 && active_reg == '0)
        else $error("frame state not cleared after final byte");

    // A run never covers more than 128 pixels.
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:8] <= 8'd128)
        else $error("run length above 128");

    // An empty run is only sent as the end-of-frame request.
    a_empty_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15:8] == 8'd0 |-> m_tlast)
        else $error("empty run without frame end");

    // The active segment count never passes the number of offset slots.
    a_active_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg <= SEG_W'(MAX_SEGMENTS))
        else $error("active segment out of range");

endmodule

// ===== tb/dicom_rle_packbits_decoder_checker.sv =====
// Checker for the DICOM RLE PackBits decoder: watches both streams and the register port.
// Predicts every run request from the accepted bytes and compares it field by field.
// Depends on dicrle_pkg.
`timescale 1ns / 1ps

module dicom_rle_packbits_decoder_checker
    import dicrle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [24:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [7:0] value, [15:8] run_length, [39:16] pixel_start,
                                   // [41:40] sample_index, [43:42] byte_lane
    input  logic        m_tlast,   // frame_done
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          runs_pending,
    output int          mismatch_count
);

    localparam logic [1:0] STATUS_OK              = 2'd0;
    localparam logic [1:0] STATUS_SHORT_HEADER    = 2'd1;
    localparam logic [1:0] STATUS_EXCESS_SEGMENTS = 2'd2;

    typedef struct packed {
        logic [7:0]  value;
        logic [7:0]  run_len;
        logic [23:0] pix_start;
        logic [1:0]  sample;
        logic [1:0]  lane;
        logic        done;
        logic [1:0]  status;
    } run_req_t;

    // Local copies of the configuration registers.
    logic [24:0] pixels_reg;
    logic [2:0]  bps_reg;
    logic [2:0]  spp_reg;

    // Frame decoding state.
    logic [31:0] byte_pos;
    logic [31:0] hdr_word;
    logic [31:0] seg_total;
    logic [31:0] seg_offs [MAX_SEGMENTS_DEF];
    int unsigned active_seg;
    run_mode_t   mode;
    int unsigned run_left;
    int unsigned rep_count;
    logic [24:0] pix_done;

    run_req_t expected_runs [$];

    // Byte planes per sample and channels per pixel saturate to 1..4.
    function automatic int unsigned sat14(input logic [2:0] v);
        if (v == 3'd0) begin
            return 1;
        end else if (v > 3'd4) begin
            return 4;
        end
        return v;
    endfunction

    task automatic clear_frame();
        byte_pos   = '0;
        hdr_word   = '0;
        seg_total  = '0;
        active_seg = 0;
        mode       = MODE_HEADER;
        run_left   = 0;
        rep_count  = 0;
        pix_done   = '0;
    endtask

    // Advance the decoder by one compressed byte and queue the run request it causes.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [31:0] p;
        int unsigned bps;
        int unsigned planes;
        int unsigned nseg;
        int unsigned seg;
        int unsigned count;
        int unsigned npix;
        int unsigned n;
        logic        emit;
        run_req_t    r;
        p      = byte_pos;
        bps    = sat14(bps_reg);
        planes = bps * sat14(spp_reg);
        emit   = 1'b0;
        count  = 0;
        r      = '0;
        if (p < HEADER_BYTES) begin
            // Header bytes shift in little-endian; every fourth byte completes a word.
            hdr_word = {b, hdr_word[31:8]};
            if (p[1:0] == 2'b11) begin
                if (p == 32'd3) begin
                    seg_total = hdr_word;
                end else begin
                    seg_offs[(p - 32'd4) >> 2] = hdr_word;
                end
            end
        end else begin
            nseg = (seg_total < MAX_SEGMENTS_DEF) ? seg_total : MAX_SEGMENTS_DEF;
            // Start every segment whose offset has been reached, in index order.
            while (active_seg < nseg && seg_offs[active_seg] <= p) begin
                active_seg++;
                mode      = MODE_HEADER;
                run_left  = 0;
                rep_count = 0;
                pix_done  = '0;
            end
            if (active_seg > 0 && active_seg - 1 < planes) begin
                seg = active_seg - 1;
                case (mode)
                    MODE_LITERAL: begin
                        count = 1;
                        if (run_left > 0) run_left--;
                        if (run_left == 0) mode = MODE_HEADER;
                    end
                    MODE_REPLICATE: begin
                        count = rep_count;
                        mode  = MODE_HEADER;
                    end
                    default: begin
                        if (b < 8'd128) begin
                            mode     = MODE_LITERAL;
                            run_left = b + 1;
                        end else if (b != NOOP_CODE) begin
                            mode      = MODE_REPLICATE;
                            rep_count = 257 - b;
                        end else begin
                            mode = MODE_HEADER;
                        end
                    end
                endcase
                // Clip the run to the plane size.
                if (count > 0) begin
                    npix = (pixels_reg > MAX_PIXELS) ? MAX_PIXELS : pixels_reg;
                    if (pix_done < npix) begin
                        n           = (count < npix - pix_done) ? count : npix - pix_done;
                        emit        = 1'b1;
                        r.value     = b;
                        r.run_len   = 8'(n);
                        r.pix_start = pix_done[23:0];
                        r.sample    = 2'(seg / bps);
                        r.lane      = 2'(bps - 1 - seg % bps);
                        pix_done    = pix_done + 25'(n);
                    end
                end
            end
        end
        if (p != 32'hFFFF_FFFF) byte_pos = p + 32'd1;
        if (last && p < HEADER_BYTES - 1) begin
            r.status = STATUS_SHORT_HEADER;
        end else if (seg_total > planes) begin
            r.status = STATUS_EXCESS_SEGMENTS;
        end else begin
            r.status = STATUS_OK;
        end
        if (emit || last) begin
            r.done = last;
            expected_runs = {expected_runs, r};
        end
        if (last) clear_frame();
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        run_req_t r;
        if (!aresetn) begin
            pixels_reg = PIXELS_RESET;
            bps_reg    = BPS_RESET;
            spp_reg    = SPP_RESET;
            foreach (seg_offs[i]) seg_offs[i] = '0;
            clear_frame();
            expected_runs.delete();
        end else begin
            // Compare an accepted run request with the oldest prediction.
            if (m_tvalid && m_tready) begin
                if (expected_runs.size() == 0) begin
                    $display("%0t: unexpected run request, expected none, actual %h last %b user %0h",
                             $time, m_tdata, m_tlast, m_tuser);
                    mismatch_count++;
                end else begin
                    r = expected_runs.pop_front();
                    check_field("value", r.value, m_tdata[7:0]);
                    check_field("run_length", r.run_len, m_tdata[15:8]);
                    check_field("pixel_start", r.pix_start, m_tdata[39:16]);
                    check_field("sample_index", r.sample, m_tdata[41:40]);
                    check_field("byte_lane", r.lane, m_tdata[43:42]);
                    check_field("frame_done", r.done, m_tlast);
                    check_field("status", r.status, m_tuser);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_PIXELS_PER_FRAME:  pixels_reg = cfg_wr_data;
                    CFG_BYTES_PER_SAMPLE:  bps_reg    = cfg_wr_data[2:0];
                    CFG_SAMPLES_PER_PIXEL: spp_reg    = cfg_wr_data[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
        end
        runs_pending = expected_runs.size();
    end

endmodule

// ===== tb/dicom_rle_packbits_decoder_test.sv =====
// Top of the DICOM RLE PackBits decoder testbench: clock, reset, frame stimulus and verdict.
// Depends on dicrle_pkg, the decoder RTL and dicom_rle_packbits_decoder_checker.
`timescale 1ns / 1ps

module dicom_rle_packbits_decoder_test;
    import dicrle_pkg::*;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = '0;
    logic [24:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;   // [7:0] data_byte
    logic        s_tlast     = 1'b0; // last
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;            // [7:0] value, [15:8] run_length, [39:16] pixel_start,
                                     // [41:40] sample_index, [43:42] byte_lane
    logic        m_tlast;            // frame_done
    logic [1:0]  m_tuser;            // [1:0] status
    int          runs_pending;
    int          mismatch_count;

    // Idle and stall rates in percent for the current phase.
    int          send_idle  = 0;
    int          recv_stall = 0;
    int unsigned sent_bytes = 0;
    logic [2:0]  cur_bps    = BPS_RESET;
    logic [2:0]  cur_spp    = SPP_RESET;
    logic [7:0]  frame_bytes [$];

    dicom_rle_packbits_decoder dut (.*);

    dicom_rle_packbits_decoder_checker run_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver stalls at random at the current rate.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall);
    end

    // Offer one byte, idling first at the sender's rate, and wait until it is taken.
    task automatic push_byte(input logic [7:0] d, input logic l);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tlast  = l;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait with no request offered until every predicted run has arrived.
    task automatic drain_decoder();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (runs_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_config(input logic [24:0] pixels, input logic [2:0] bps,
                              input logic [2:0] spp);
        cfg_index_t idx [3];
        logic [24:0] val [3];
        idx = '{CFG_PIXELS_PER_FRAME, CFG_BYTES_PER_SAMPLE, CFG_SAMPLES_PER_PIXEL};
        val = '{pixels, 25'(bps), 25'(spp)};
        for (int i = 0; i < 3; i++) begin
            @(negedge aclk);
            cfg_wr_en   = 1'b1;
            cfg_addr    = idx[i];
            cfg_wr_data = val[i];
        end
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cur_bps   = bps;
        cur_spp   = spp;
    endtask

    // Append one byte to the frame under construction.
    task automatic add_byte(input logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
    endtask

    // Send the built frame; sometimes the sender holds off mid-frame until all runs are out.
    task automatic send_frame(input bit force_hold);
        int hold_at;
        hold_at = -1;
        if (force_hold || $urandom_range(3) == 0) begin
            hold_at = $urandom_range(frame_bytes.size() / 2, frame_bytes.size() - 1);
        end
        foreach (frame_bytes[i]) begin
            if (i == hold_at) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                while (runs_pending != 0) @(negedge aclk);
            end
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        sent_bytes += frame_bytes.size();
    endtask

    // Mostly well-formed PackBits runs with random content, some stray bytes.
    task automatic gen_segment(input int unsigned len);
        int unsigned left;
        int unsigned lim;
        int unsigned cnt;
        int unsigned pick;
        left = len;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (left == 1 || pick >= 92) begin
                add_byte(8'($urandom));
                left -= 1;
            end else if (pick < 45) begin
                lim = (left - 1 < 128) ? left - 1 : 128;
                if ($urandom_range(9) != 0 && lim > 6) lim = 6;
                cnt = $urandom_range(1, lim);
                add_byte(8'(cnt - 1));
                repeat (cnt) add_byte(8'($urandom));
                left -= cnt + 1;
            end else if (pick < 85) begin
                add_byte(8'($urandom_range(129, 255)));
                add_byte(8'($urandom));
                left -= 2;
            end else begin
                add_byte(NOOP_CODE);
                left -= 1;
            end
        end
    endtask

    // Build a random frame: header with the segment count and offsets, then the segments.
    task automatic gen_frame();
        int unsigned planes;
        int unsigned maxk;
        int unsigned nuse;
        int unsigned pos;
        logic [31:0] nseg_word;
        logic [31:0] offs [15];
        int unsigned seglen [15];
        frame_bytes.delete();
        if ($urandom_range(19) == 0) begin
            // Frame cut off inside the header.
            repeat ($urandom_range(1, 63)) add_byte(8'($urandom));
            return;
        end
        planes = ((cur_bps == 0) ? 1 : (cur_bps > 4) ? 4 : cur_bps) *
                 ((cur_spp == 0) ? 1 : (cur_spp > 4) ? 4 : cur_spp);
        maxk = (planes < 15) ? planes : 15;
        case ($urandom_range(9))
            0:       nseg_word = '0;
            1:       nseg_word = $urandom;
            2:       nseg_word = (planes < 15) ? $urandom_range(planes + 1, 15)
                                               : $urandom_range(16, 40);
            default: nseg_word = $urandom_range(1, maxk);
        endcase
        nuse = (nseg_word < 15) ? nseg_word : 15;
        pos  = HEADER_BYTES;
        for (int k = 0; k < 15; k++) begin
            seglen[k] = 0;
            offs[k]   = $urandom;
            if (k < nuse) begin
                seglen[k] = ($urandom_range(15) == 0) ? $urandom_range(100, 140)
                                                      : $urandom_range(0, 60 / nuse + 2);
                offs[k] = pos;
                // An offset now and then lands inside the header or far away.
                if ($urandom_range(9) == 0) begin
                    offs[k] = $urandom_range(1) ? $urandom : $urandom_range(0, 63);
                end
                pos += seglen[k];
            end
        end
        put_word(nseg_word);
        foreach (offs[k]) put_word(offs[k]);
        for (int k = 0; k < nuse; k++) gen_segment(seglen[k]);
    endtask

    initial begin
        int frame_no;
        int unsigned rand_start;
        logic [24:0] pix;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: a one-byte frame, then a three-byte frame, both short headers.
        frame_bytes.delete();
        add_byte(8'h00);
        send_frame(1'b0);
        frame_bytes.delete();
        repeat (3) add_byte(8'($urandom));
        send_frame(1'b0);

        // Directed at reset settings: three segments against two planes, the first offset
        // inside the header, the third out of order; literal, longest replicate, no-op.
        frame_bytes.delete();
        put_word(32'd3);
        put_word(32'd0);
        put_word(32'd70);
        put_word(32'd68);
        repeat (12) put_word($urandom);
        add_byte(8'h00);
        add_byte(8'h12);
        add_byte(8'h81);
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte(8'h34);
        add_byte(NOOP_CODE);
        add_byte(8'h7F);
        add_byte(8'h55);
        send_frame(1'b0);

        // Directed clipping: a three-pixel plane, the last run cut short on the final byte.
        drain_decoder();
        set_config(25'd3, 3'd2, 3'd1);
        frame_bytes.delete();
        put_word(32'd1);
        put_word(32'd64);
        repeat (14) put_word($urandom);
        add_byte(8'h01);
        add_byte(8'h10);
        add_byte(8'h20);
        add_byte(8'hFE);
        add_byte(8'h33);
        send_frame(1'b0);

        // Random frames, each with fresh settings, cycling through the idling phases.
        frame_no   = 0;
        rand_start = sent_bytes;
        while (sent_bytes - rand_start < 750) begin
            drain_decoder();
            case (frame_no % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 79; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 79; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase
            case ($urandom_range(9))
                0:       pix = '0;
                1:       pix = 25'd1;
                2:       pix = MAX_PIXELS;
                3:       pix = 25'h1FF_FFFF;
                4:       pix = 25'($urandom);
                default: pix = 25'($urandom_range(2, 40));
            endcase
            set_config(pix,
                       ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4)),
                       ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4)));
            gen_frame();
            send_frame(frame_no == 0);
            frame_no++;
        end

        drain_decoder();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && runs_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/dicrle_pkg.sv
hw/rtl/dicrle_seg_track.sv
hw/rtl/dicom_rle_packbits_decoder.sv
tb/dicom_rle_packbits_decoder_checker.sv
tb/dicom_rle_packbits_decoder_test.sv
